>>> design/epv_pkg.sv
// shared types and constants for the encoder position and velocity block
`default_nettype none
package epv_pkg;
  localparam int WINDOW_LEN = 101;
  localparam int WIN_AW = $clog2(WINDOW_LEN);
  localparam int WIN_FW = $clog2(WINDOW_LEN + 1);
  localparam logic [29:0] NS_PER_S = 30'd1_000_000_000;
  localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] POS_MIN_MAG = 48'h8000_0000_0000;
  localparam logic [5:0] POS_STEPS = 6'd48;
  localparam logic [5:0] SPD_STEPS = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_PDIV, S_PFIN, S_MUL1, S_MUL2, S_MSUM, S_SCHK,
    S_SDIV, S_SFIN, S_DONE
  } epv_state_t;

  typedef struct packed {
    logic [47:0] pos;
    logic [31:0] ns;
  } win_entry_t;
endpackage
`default_nettype wire

>>> design/encoder_position_velocity.sv
// top level: encoder unwrap, position scaling and windowed speed
// a cycle sample passes from request to result through the shared
// radix-2 divider (48 steps for position, 32 for speed), the multiply states S_MUL1 and S_MUL2
// and control, and finishes sooner when a division is skipped; an armed index edge yields a result, an unarmed one none
// one request at a time: a new request is taken only back in idle, once the last result is loaded into the outputs
// reset clears control, unwrap state and window pointers; scale resets to 1
`default_nettype none
module encoder_position_velocity import epv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [15:0] raw_count,
  input  wire logic [31:0] ns_time,
  input  wire logic [31:0] us_time,
  input  wire logic        latch_enable,
  input  wire logic        index_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [47:0] position_q,
  output logic [31:0]      speed_q,
  output logic [31:0]      interval_us,
  output logic             index_seen,
  output logic             pin_copy,
  output logic             clear_counter
);
  epv_state_t state, state_next;

  logic [31:0] counts_per_unit;
  logic        it_mode, it_latch, it_pin;
  logic [15:0] it_raw;
  logic [31:0] it_ns, it_us;

  logic [47:0] shifted_position;
  logic        old_latch, armed, fired;
  logic [WIN_AW-1:0] window_head;
  logic [WIN_FW-1:0] window_fill;
  logic [31:0] last_us, before_last_us;

  win_entry_t win_mem [WINDOW_LEN];
  win_entry_t rd_data;
  logic [WIN_AW-1:0] wr_slot;
  logic        two_plus;

  logic [47:0] res_pos;
  logic [31:0] res_speed, res_interval;
  logic        res_seen, res_pin, res_clear;

  // shared divider
  logic [31:0] rem, dvs;
  logic [47:0] sh;
  logic [5:0]  step;
  logic        neg, sat;
  logic [32:0] trial;
  logic        trial_ge;

  logic [48:0] dpos;
  logic [31:0] dt;
  logic [53:0] prod_lo;
  logic [54:0] prod_hi;
  logic [78:0] prod;

  // unwrap and magnitude
  logic [15:0] d16;
  logic [47:0] sp_new, pos_u, mag;
  logic        pos_sat;
  logic [47:0] pq;
  logic signed [48:0] diff;
  logic [WIN_AW:0] sum_hf, sum_h1;
  logic [WIN_AW-1:0] slot_c, head_c;
  logic [WIN_FW-1:0] fill_c;

  always_comb begin
    d16 = (it_raw ^ 16'h8000) - shifted_position[15:0];
    sp_new = shifted_position + {{32{d16[15]}}, d16};
    pos_u = sp_new + 48'd32768;
    mag = pos_u[47] ? (48'd0 - pos_u) : pos_u;
    pos_sat = {16'd0, mag[47:32]} >= counts_per_unit;
    sum_hf = {1'b0, window_head} + (WIN_AW + 1)'(window_fill);
    sum_h1 = {1'b0, window_head} + 1'b1;
    if (window_fill < WIN_FW'(WINDOW_LEN)) begin
      slot_c = (sum_hf >= (WIN_AW + 1)'(WINDOW_LEN)) ?
               WIN_AW'(sum_hf - (WIN_AW + 1)'(WINDOW_LEN)) : WIN_AW'(sum_hf);
      head_c = window_head;
      fill_c = window_fill + 1'b1;
    end else begin
      slot_c = window_head;
      head_c = (sum_h1 >= (WIN_AW + 1)'(WINDOW_LEN)) ? '0 : WIN_AW'(sum_h1);
      fill_c = window_fill;
    end
  end

  always_comb begin
    trial = {rem, sh[47]};
    trial_ge = trial >= {1'b0, dvs};
    if (sat) begin
      pq = neg ? (48'd0 - POS_MIN_MAG) : POS_MAX;
    end else if (neg) begin
      pq = 48'd0 - ((sh > POS_MIN_MAG) ? POS_MIN_MAG : sh);
    end else begin
      pq = (sh > POS_MAX) ? POS_MAX : sh;
    end
    diff = $signed({pq[47], pq}) - $signed({rd_data.pos[47], rd_data.pos});
    prod = {prod_hi, 24'd0} + {25'd0, prod_lo};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: begin
        if (it_mode) state_next = armed ? S_DONE : S_IDLE;
        else if (pos_sat) state_next = S_PFIN;
        else state_next = S_PDIV;
      end
      S_PDIV:  if (step == POS_STEPS - 6'd1) state_next = S_PFIN;
      S_PFIN:  begin
        if (!two_plus || (it_ns == rd_data.ns)) state_next = S_DONE;
        else state_next = S_MUL1;
      end
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_MSUM;
      S_MSUM:  state_next = S_SCHK;
      S_SCHK:  state_next = (prod[78:32] >= {15'd0, dt}) ? S_DONE : S_SDIV;
      S_SDIV:  if (step == SPD_STEPS - 6'd1) state_next = S_SFIN;
      S_SFIN:  state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) counts_per_unit <= 32'd1;
    else if (cfg_we && (cfg_wdata != 32'd0)) counts_per_unit <= cfg_wdata;
  end

  // window memory: written once the position is known, oldest read at start
  always_ff @(posedge clk) begin
    if (state == S_PFIN) win_mem[wr_slot] <= '{pos: pq, ns: it_ns};
    if (state == S_START) rd_data <= win_mem[head_c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shifted_position <= '0;
      old_latch <= 1'b0;
      armed <= 1'b0;
      fired <= 1'b0;
      window_head <= '0;
      window_fill <= '0;
      last_us <= '0;
      before_last_us <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_START: begin
          if (it_mode) begin
            if (armed) begin
              armed <= 1'b0;
              fired <= 1'b1;
              window_head <= '0;
              window_fill <= '0;
              shifted_position <= '0;
            end
          end else begin
            if (it_latch && !old_latch) armed <= 1'b1;
            old_latch <= it_latch;
            fired <= 1'b0;
            before_last_us <= last_us;
            last_us <= it_us;
            shifted_position <= sp_new;
            window_head <= head_c;
            window_fill <= fill_c;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_mode <= mode;
      it_raw <= raw_count;
      it_ns <= ns_time;
      it_us <= us_time;
      it_latch <= latch_enable;
      it_pin <= index_level;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      position_q <= res_pos;
      speed_q <= res_speed;
      interval_us <= res_interval;
      index_seen <= res_seen;
      pin_copy <= res_pin;
      clear_counter <= res_clear;
    end
    case (state)
      S_START: begin
        res_pin <= it_pin;
        res_speed <= '0;
        if (it_mode) begin
          res_pos <= '0;
          res_interval <= '0;
          res_seen <= 1'b0;
          res_clear <= 1'b1;
        end else begin
          res_interval <= it_us - before_last_us;
          res_seen <= fired;
          res_clear <= 1'b0;
          wr_slot <= slot_c;
          two_plus <= fill_c >= WIN_FW'(2);
          neg <= pos_u[47];
          sat <= pos_sat;
          rem <= {16'd0, mag[47:32]};
          sh <= {mag[31:0], 16'd0};
          dvs <= counts_per_unit;
          step <= '0;
        end
      end
      S_PDIV, S_SDIV: begin
        rem <= trial_ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        sh <= {sh[46:0], trial_ge};
        step <= step + 6'd1;
      end
      S_PFIN: begin
        res_pos <= pq;
        dpos <= diff[48] ? 49'(-diff) : 49'(diff);
        dt <= it_ns - rd_data.ns;
      end
      S_MUL1: prod_lo <= dpos[23:0] * NS_PER_S;
      S_MUL2: prod_hi <= dpos[48:24] * NS_PER_S;
      S_MSUM: begin
        rem <= prod[63:32];
        sh <= {prod[31:0], 16'd0};
        dvs <= dt;
        step <= '0;
      end
      S_SCHK: if (prod[78:32] >= {15'd0, dt}) res_speed <= 32'hFFFF_FFFF;
      S_SFIN: res_speed <= sh[31:0];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> design/epv_checker.sv
// port-level checker for the encoder position and velocity block
`default_nettype none
module epv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [47:0] position_q,
  input wire logic [31:0] speed_q,
  input wire logic [31:0] interval_us,
  input wire logic        index_seen,
  input wire logic        clear_counter
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position_q) && $stable(speed_q))
    else $error("result changed while stalled");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_counter |-> position_q == 48'd0 && speed_q == 32'd0 &&
      interval_us == 32'd0 && !index_seen)
    else $error("clear result carries nonzero fields");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");
endmodule

bind encoder_position_velocity epv_checker u_epv_checker (.*);
`default_nettype wire

>>> tb/encoder_position_velocity_test.sv
// testbench for the encoder position and velocity block: predicted results checked per request
module encoder_position_velocity_test;
  import epv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 20000;
  localparam int INDEX_LATENCY = 10;

  typedef struct {
    logic signed [47:0] pos;
    logic [31:0] spd;
    logic [31:0] ivl;
    logic seen;
    logic pin;
    logic clr;
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [15:0] raw_count = '0;
  logic [31:0] ns_time = '0;
  logic [31:0] us_time = '0;
  logic latch_enable = 1'b0;
  logic index_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] position_q;
  logic [31:0] speed_q, interval_us;
  logic index_seen, pin_copy, clear_counter;

  encoder_position_velocity i_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .mode, .raw_count,
    .ns_time, .us_time, .latch_enable, .index_level, .out_valid, .out_ready,
    .position_q, .speed_q, .interval_us, .index_seen, .pin_copy, .clear_counter
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] scale;
  logic [47:0] unwrapped;
  logic prev_latch, armed, fired;
  logic signed [47:0] pos_win [WINDOW_LEN];
  logic [31:0] ns_win [WINDOW_LEN];
  int head, fill;
  logic [31:0] us_last, us_before;

  motion_t pending[$];
  int mismatches = 0;
  int results_seen = 0;
  int sent = 0;
  int idle_cycles = 0;
  int ns_clock = 0;
  bit hold_rx = 0;
  int hold_len = 0;
  logic [31:0] us_clock = 0;

  function automatic logic signed [47:0] scale_counts(logic signed [47:0] counts);
    logic [63:0] mag, q;
    mag = counts < 0 ? 64'(-64'(counts)) : 64'(counts);
    q = (mag << 16) / 64'(scale);
    if (counts < 0) begin
      if (q > 64'(POS_MIN_MAG)) q = 64'(POS_MIN_MAG);
      return 48'(-q);
    end
    if (q > 64'(POS_MAX)) q = 64'(POS_MAX);
    return q[47:0];
  endfunction

  function automatic logic [31:0] speed_of(logic [63:0] dpos, logic [31:0] dt);
    logic [63:0] q1, r1, q;
    if (dt == 0) return 0;
    q1 = dpos / dt;
    r1 = dpos % dt;
    if (q1 > 4) return 32'hFFFF_FFFF;
    q = q1 * 64'd1_000_000_000 + (r1 * 64'd1_000_000_000) / dt;
    if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  task automatic predict_motion(logic m, logic [15:0] raw, logic [31:0] ns, logic [31:0] us,
                                logic lat, logic pin);
    motion_t r;
    logic [47:0] c, d, pu;
    logic signed [48:0] diff;
    int slot, newest;
    r = '{default: '0};
    r.pin = pin;
    if (m) begin
      if (!armed) return;
      armed = 0; fired = 1; head = 0; fill = 0; unwrapped = 0;
      r.clr = 1;
      pending.push_back(r);
      return;
    end
    if (lat && !prev_latch) armed = 1;
    prev_latch = lat;
    if (fired) begin
      r.seen = 1; fired = 0;
    end
    r.ivl = us - us_before;
    us_before = us_last;
    us_last = us;
    c = (48'(raw) - 48'd32768) & M48;
    d = (c - unwrapped) & 48'hFFFF;
    unwrapped = unwrapped + d - (d >= 48'd32768 ? 48'd65536 : 48'd0);
    pu = unwrapped + 48'd32768;
    r.pos = scale_counts(pu);
    if (fill < WINDOW_LEN) begin
      slot = (head + fill) % WINDOW_LEN;
      fill++;
    end else begin
      slot = head;
      head = (head + 1) % WINDOW_LEN;
    end
    pos_win[slot] = r.pos;
    ns_win[slot] = ns;
    if (fill >= 2) begin
      newest = (head + fill - 1) % WINDOW_LEN;
      diff = pos_win[newest] - pos_win[head];
      r.spd = speed_of(diff < 0 ? 64'(-64'(diff)) : 64'(diff), ns_win[newest] - ns_win[head]);
    end
    pending.push_back(r);
  endtask

  task automatic random_gap();
    int g;
    g = $urandom_range(0, 99) < 70 ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(20, 200)
                                                                    : $urandom_range(1, 4));
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one request through the handshake, prediction taken at acceptance
  // valid stays up after acceptance; the next request or an idle stretch decides it
  task automatic send_request(logic m, logic [15:0] raw, logic [31:0] ns, logic [31:0] us,
                              logic lat, logic pin, bit gaps = 1);
    if (gaps) random_gap();
    in_valid <= 1'b1;
    mode <= m; raw_count <= raw; ns_time <= ns; us_time <= us;
    latch_enable <= lat; index_level <= pin;
    do @(posedge clk); while (!in_ready);
    predict_motion(m, raw, ns, us, lat, pin);
    sent++;
  endtask

  task automatic sample(logic [15:0] raw, logic lat = 0, logic pin = 0, bit gaps = 1);
    ns_clock += $urandom_range(1000, 60000);
    us_clock += $urandom_range(1, 100);
    send_request(1'b0, raw, ns_clock, us_clock, lat, pin, gaps);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (INDEX_LATENCY) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v != 0) scale = v;
  endtask

  task automatic arm_and_index(logic pin);
    sample(16'($urandom), 1'b0);
    sample(16'($urandom), 1'b1);
    send_request(1'b1, 16'($urandom), $urandom, $urandom, 1'($urandom), pin);
  endtask

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (rst || hold_rx) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 75);
  end

  always @(posedge clk) begin
    motion_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pos=%0d", position_q);
      end else begin
        e = pending.pop_front();
        if (position_q !== e.pos || speed_q !== e.spd || interval_us !== e.ivl ||
            index_seen !== e.seen || pin_copy !== e.pin || clear_counter !== e.clr) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp pos=%0d spd=%0d ivl=%0d seen=%b pin=%b clr=%b",
                      " / act %0d %0d %0d %b %b %b"},
                     e.pos, e.spd, e.ivl, e.seen, e.pin, e.clr, position_q, speed_q,
                     interval_us, index_seen, pin_copy, clear_counter);
        end
      end
    end
  end

  // watchdog on cycles without any request or result accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_rx) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    sample(16'h8000);
    sample(16'h0000);
    sample(16'hFFFF);
    sample(16'h7FFF);
    sample(16'h8000);
    // index edge while unarmed is dropped
    send_request(1'b1, 16'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    arm_and_index(1'b1);
    sample(16'h0001, 1'b1, 1'b1);
    // zero elapsed time gives zero speed
    send_request(1'b0, 16'h0100, ns_clock, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_request(1'b0, 16'h4000, 32'h0, 32'h0, 1'b0, 1'b1);
    // large jumps for speed saturation
    send_request(1'b0, 16'hC000, 32'h1, 32'h5, 1'b0, 1'b0);
    arm_and_index(1'b0);
    sample(16'hFFFF);
  endtask

  task automatic test_scale_extremes();
    write_scale(32'hFFFF_FFFF);
    repeat (6) sample(16'($urandom));
    write_scale(32'h0);
    repeat (3) sample(16'($urandom));
    write_scale(32'd1);
    // samples of 16'h7FFF or 16'h8001 at unit scale, so the position moves by small steps either way
    repeat (12) sample(16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8001));
  endtask

  task automatic test_random();
    logic [15:0] cnt;
    int steps;
    cnt = 16'($urandom);
    for (int i = 0; i < 330; i++) begin
      if (i % 80 == 0) write_scale($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 5000));
      case ($urandom_range(0, 19))
        0: arm_and_index(1'($urandom));
        1: send_request(1'b1, 16'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom));
        2: begin
          cnt = 16'($urandom);
          send_request(1'b0, cnt, $urandom, $urandom, 1'($urandom), 1'($urandom));
        end
        default: begin
          steps = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 400);
          cnt = cnt + 16'(steps) - 16'($urandom_range(0, 200));
          sample(cnt, 1'($urandom_range(0, 15) == 0), 1'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    hold_rx = 1;
    fork
      begin
        repeat (hold_len) @(posedge clk);
        hold_rx = 0;
      end
      repeat (8) sample(16'($urandom), 1'b0, 1'b0, 0);
    join
    drain();
    // back to back with no gaps
    repeat (20) sample(16'($urandom_range(0, 300)), 1'b0, 1'b0, 0);
  endtask

  initial begin
    scale = 1; unwrapped = 0; prev_latch = 0; armed = 0; fired = 0;
    head = 0; fill = 0; us_last = 0; us_before = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_scale_extremes();
    test_random();
    test_backpressure();
    drain();
    repeat (200) @(posedge clk);
    $display("requests sent: %0d, results checked: %0d, mismatches: %0d",
             sent, results_seen, mismatches);
    $display("covered wrap steps, index zeroing, scale extremes and output back-pressure");
    if (mismatches == 0 && pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
